// ===== rtl/nbbc_pkg.sv =====
package nbbc_pkg;

    localparam int CHAN_W    = 8;
    localparam int POS_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 2'd2;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET     = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET    = 13'd480;
    localparam logic [CHAN_W-1:0] WHITE_THRESHOLD_RESET = 8'd200;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [POS_W-1:0]  crop_left;
        logic [POS_W-1:0]  crop_top;
        logic [SIZE_W-1:0] crop_width;
        logic [SIZE_W-1:0] crop_height;
        logic              frame_empty;
    } crop_t;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [CHAN_W-1:0] white_threshold;
    } cfg_t;

    typedef struct packed {
        logic  frame_last;
        crop_t result;
    } track_t;

endpackage

// ===== rtl/nbbc_if.sv =====
interface nbbc_pixel_if
    import nbbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface nbbc_crop_if
    import nbbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  crop_left;
    logic [POS_W-1:0]  crop_top;
    logic [SIZE_W-1:0] crop_width;
    logic [SIZE_W-1:0] crop_height;
    logic              frame_empty;

    modport source (
        output valid, output crop_left, output crop_top, output crop_width,
        output crop_height, output frame_empty, input ready
    );
    modport sink (
        input valid, input crop_left, input crop_top, input crop_width,
        input crop_height, input frame_empty, output ready
    );
endinterface

// ===== rtl/nbbc_cfg_regs.sv =====
module nbbc_cfg_regs
    import nbbc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [CHAN_W-1:0] white_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= FRAME_WIDTH_RESET;
            frame_height_reg    <= FRAME_HEIGHT_RESET;
            white_threshold_reg <= WHITE_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[SIZE_W-1:0];
                REG_WHITE_THRESHOLD: white_threshold_reg <= cfg_data[CHAN_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.frame_width     = frame_width_reg;
    assign cfg.frame_height    = frame_height_reg;
    assign cfg.white_threshold = white_threshold_reg;

endmodule

// ===== rtl/nbbc_tracker.sv =====
module nbbc_tracker
    import nbbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   step,
    input  pixel_t pix,
    input  cfg_t   cfg,
    output track_t track
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CSW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int RSW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
    localparam int CXW = (CW > POS_W) ? CW : POS_W;
    localparam int RXW = (RW > POS_W) ? RW : POS_W;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] least_col_reg;
    logic [CW-1:0] greatest_col_reg;
    logic [RW-1:0] least_row_reg;
    logic [RW-1:0] greatest_row_reg;
    logic          seen_reg;

    logic [CSW-1:0] fw;
    logic [CSW-1:0] last_col;
    logic [RSW-1:0] fh;
    logic [RSW-1:0] last_row;
    logic           row_end;
    logic           frame_last;
    logic           content;

    logic [CW-1:0] least_col_next;
    logic [CW-1:0] greatest_col_next;
    logic [RW-1:0] least_row_next;
    logic [RW-1:0] greatest_row_next;
    logic          seen_next;

    logic [CW:0]    col_span;
    logic [RW:0]    row_span;
    logic [CSW-1:0] col_span_x;
    logic [RSW-1:0] row_span_x;
    logic [CXW-1:0] left_x;
    logic [RXW-1:0] top_x;

    always_comb
    begin
        fw = CSW'(cfg.frame_width);
        if (fw == '0)
            last_col = '0;
        else if (fw > CSW'(MAX_WIDTH))
            last_col = CSW'(MAX_WIDTH - 1);
        else
            last_col = fw - CSW'(1);

        fh = RSW'(cfg.frame_height);
        if (fh == '0)
            last_row = '0;
        else if (fh > RSW'(MAX_HEIGHT))
            last_row = RSW'(MAX_HEIGHT - 1);
        else
            last_row = fh - RSW'(1);
    end

    assign row_end    = CSW'(col_reg) >= last_col;
    assign frame_last = row_end && (RSW'(row_reg) >= last_row);
    assign content    = (pix.blue < cfg.white_threshold) ||
                        (pix.green < cfg.white_threshold) ||
                        (pix.red < cfg.white_threshold);

    always_comb
    begin
        least_col_next    = least_col_reg;
        greatest_col_next = greatest_col_reg;
        least_row_next    = least_row_reg;
        greatest_row_next = greatest_row_reg;
        if (content)
        begin
            if (!seen_reg || col_reg < least_col_reg)
                least_col_next = col_reg;
            if (!seen_reg || col_reg > greatest_col_reg)
                greatest_col_next = col_reg;
            if (!seen_reg || row_reg < least_row_reg)
                least_row_next = row_reg;
            if (!seen_reg || row_reg > greatest_row_reg)
                greatest_row_next = row_reg;
        end
    end

    assign seen_next = seen_reg || content;

    assign col_span   = {1'b0, greatest_col_next} - {1'b0, least_col_next} + (CW+1)'(1);
    assign row_span   = {1'b0, greatest_row_next} - {1'b0, least_row_next} + (RW+1)'(1);
    assign col_span_x = CSW'(col_span);
    assign row_span_x = RSW'(row_span);
    assign left_x     = CXW'(least_col_next);
    assign top_x      = RXW'(least_row_next);

    always_comb
    begin
        track.frame_last = frame_last;
        if (seen_next)
        begin
            track.result.crop_left   = left_x[POS_W-1:0];
            track.result.crop_top    = top_x[POS_W-1:0];
            track.result.crop_width  = col_span_x[SIZE_W-1:0];
            track.result.crop_height = row_span_x[SIZE_W-1:0];
            track.result.frame_empty = 1'b0;
        end
        else
        begin
            track.result.crop_left   = '0;
            track.result.crop_top    = '0;
            track.result.crop_width  = '0;
            track.result.crop_height = '0;
            track.result.frame_empty = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            least_col_reg    <= '1;
            greatest_col_reg <= '0;
            least_row_reg    <= '1;
            greatest_row_reg <= '0;
            seen_reg         <= 1'b0;
        end
        else if (step)
        begin
            if (frame_last)
            begin
                col_reg          <= '0;
                row_reg          <= '0;
                least_col_reg    <= '1;
                greatest_col_reg <= '0;
                least_row_reg    <= '1;
                greatest_row_reg <= '0;
                seen_reg         <= 1'b0;
            end
            else
            begin
                least_col_reg    <= least_col_next;
                greatest_col_reg <= greatest_col_next;
                least_row_reg    <= least_row_next;
                greatest_row_reg <= greatest_row_next;
                seen_reg         <= seen_next;
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/nonwhite_bounding_box_crop.sv =====
// Finds the bounding box of non-white content in an RGB frame streamed one pixel per
// beat in raster order, and gives one crop beat (left, top, width, height, empty flag)
// on the last pixel of each frame. It takes one pixel every clock cycle; a pixel is
// registered, then its compare and min/max update run combinationally into the result
// register, which captures the result when the last pixel of its frame leaves the pixel
// register. Only the last pixel of a frame waits, and only while the previous result has
// not yet been taken. Sizes of 0 act as 1 and sizes above MAX_WIDTH or MAX_HEIGHT act as
// those maxima; write the registers only while no beat is in flight.
module nonwhite_bounding_box_crop
    import nbbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nbbc_pixel_if.sink            pixel,
    nbbc_crop_if.source           crop
);

    cfg_t   cfg;
    track_t track;

    pixel_t pix_reg;
    logic   pix_valid_reg;
    crop_t  crop_reg;
    logic   crop_valid_reg;
    logic   advance;

    nbbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nbbc_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .pix   (pix_reg),
        .cfg   (cfg),
        .track (track)
    );

    assign advance     = pix_valid_reg && (!track.frame_last || !crop_valid_reg || crop.ready);
    assign pixel.ready = !pix_valid_reg || advance;

    // hold the pixel beat until the tracker takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (pixel.valid && pixel.ready)
            pix_valid_reg <= 1'b1;
        else if (advance)
            pix_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            pix_reg.blue  <= pixel.blue;
            pix_reg.green <= pixel.green;
            pix_reg.red   <= pixel.red;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crop_valid_reg <= 1'b0;
        else if (advance && track.frame_last)
            crop_valid_reg <= 1'b1;
        else if (crop.ready)
            crop_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && track.frame_last)
            crop_reg <= track.result;
    end

    assign crop.valid       = crop_valid_reg;
    assign crop.crop_left   = crop_reg.crop_left;
    assign crop.crop_top    = crop_reg.crop_top;
    assign crop.crop_width  = crop_reg.crop_width;
    assign crop.crop_height = crop_reg.crop_height;
    assign crop.frame_empty = crop_reg.frame_empty;

endmodule
